// File: hdl/pli_pkg.sv
`default_nettype none
package pli_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_BELOW = 3'd2,
    ST_ABOVE = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,   // read last x
    S_CHK_LAST,
    S_CHK_FIRST,
    S_SRCH,      // issue read at mid
    S_SRCH_W,    // compare mid
    S_RD_PAIR,   // read lo-1 and lo
    S_PAIR_W,
    S_DIV,
    S_INS_RD,    // read entry pos-1
    S_INS_W,     // compare / shift one entry
    S_DONE
  } state_t;

  // Request and reply between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: hdl/pli_mul.sv
`default_nettype none
// 33x32 magnitude product split into two 33x16 partials, one per phase
module pli_mul import pli_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [63:0] prod
);
  logic [1:0]  ph_r;
  logic [32:0] a_r;
  logic [31:0] b_r;
  logic [63:0] acc_r;
  logic [49:0] part;

  // low or high half of b per phase
  assign part = (ph_r == 2'd1) ? (a_r * {1'b0, b_r[15:0]})
                               : (a_r * {1'b0, b_r[31:16]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 2'd0;
    end else if (start) begin
      ph_r <= 2'd1;
    end else if (ph_r == 2'd1) begin
      ph_r <= 2'd2;
    end else if (ph_r == 2'd2) begin
      ph_r <= 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= 64'd0;
    end else if (ph_r == 2'd1) begin
      acc_r <= {14'd0, part};
    end else if (ph_r == 2'd2) begin
      acc_r <= acc_r + {part[47:0], 16'd0};
    end
  end

  assign done = (ph_r == 2'd0) && !start;
  assign prod = acc_r;
endmodule
`default_nettype wire

// File: hdl/pli_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; only the low 32 quotient bits are returned
module pli_div import pli_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [6:0]  cnt_r;
  logic [63:0] num_r;
  logic [31:0] den_r;
  logic [32:0] rem_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_r[31:0], num_r[63]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into num_r from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= 33'd0;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial;
        num_r <= {num_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted;
        num_r <= {num_r[62:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r[31:0];
endmodule
`default_nettype wire

// File: hdl/pli_mem.sv
`default_nettype none
// Node store: x and y side by side, one write and two reads, registered data
module pli_mem import pli_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic [63:0]        rdata_a,
  output logic [63:0]        rdata_b
);
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// File: hdl/piecewise_linear_interp_table.sv
`default_nettype none
// Channel | ports                              | dir | handshake
// input   | in_opcode, in_key_x, in_node_y     | in  | start & !busy
// result  | out_y_value, out_status            | out | out_valid, one cycle
//
// One word at a time. Clear, no-op, add on a full table and query on fewer than two nodes go
// from idle straight to the done state. A query above range ends after the last-x check, one
// below range after the first-x check. Others binary-search (up to 8 steps at full depth), then
// return the first y when the key equals the first x, else read the pair, multiply and divide.
// An add shifts entries up one place, from the end, until its slot opens. Reset clears the node
// count and state only. The receiver cannot stall; busy is high until the result strobe.
module piecewise_linear_interp_table import pli_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic signed [31:0] in_key_x,
  input  wire logic signed [31:0] in_node_y,
  output logic             out_valid,
  output logic signed [31:0] out_y_value,
  output logic [2:0]       out_status
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  // fraction bits cancel in the ratio; kept for the fixed-point format
  localparam int FB = FRAC_BITS;

  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [1:0]  op_r;
  logic signed [31:0] key_r, ny_r;
  logic signed [31:0] yv_r, yv_nxt;
  logic [2:0]  ss_r, ss_nxt;
  logic        neg_r;
  logic signed [31:0] y0_r;
  logic [1:0]  ph_r, ph_nxt;

  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [63:0]   wdata, da, db;
  logic [CW-1:0] mid;
  logic signed [31:0] xa, ya, xb, yb;
  logic signed [32:0] dy;
  logic [32:0] dymag;
  logic [31:0] dnum, dden;
  logic        mstart, mdone;
  logic [63:0] prod;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign xa = da[63:32];
  assign ya = da[31:0];
  assign xb = db[63:32];
  assign yb = db[31:0];
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  pli_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(da), .rdata_b(db)
  );

  // lerp operands from the pair (a = lo-1, b = lo)
  assign dy    = {yb[31], yb} - {ya[31], ya};
  assign dymag = dy[32] ? 33'(-dy) : 33'(dy);
  assign dnum  = 32'(key_r - xa);
  assign dden  = 32'(xb - xa);

  pli_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(dymag), .b(dnum),
    .done(mdone), .prod(prod)
  );

  pli_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [31:0] den_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          case (op_t'(in_opcode))
            OP_CLEAR: st_nxt = S_DONE;
            OP_ADD:   st_nxt = (cnt_r >= CW'(TABLE_DEPTH)) ? S_DONE : S_INS_RD;
            OP_QUERY: st_nxt = (cnt_r < CW'(2)) ? S_DONE : S_RD_LAST;
            default:  st_nxt = S_DONE;
          endcase
        end
      end
      S_RD_LAST:   st_nxt = S_CHK_LAST;
      S_CHK_LAST:  st_nxt = (key_r > xa) ? S_DONE : S_CHK_FIRST;
      S_CHK_FIRST: st_nxt = (key_r < xb) ? S_DONE : S_SRCH;
      S_SRCH:      st_nxt = (lo_r < hi_r) ? S_SRCH_W : S_RD_PAIR;
      S_SRCH_W:    st_nxt = S_SRCH;
      S_RD_PAIR:   st_nxt = (lo_r == '0) ? S_DONE : S_PAIR_W;
      S_PAIR_W:    st_nxt = S_DIV;
      S_DIV:       st_nxt = (ph_r == 2'd2 && drsp.done) ? S_DONE : S_DIV;
      S_INS_RD:    st_nxt = (pos_r == '0) ? S_DONE : S_INS_W;
      S_INS_W:     st_nxt = (xa > key_r) ? S_INS_RD : S_DONE;
      S_DONE:      st_nxt = S_IDLE;
      default:     st_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt = cnt_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    pos_nxt = pos_r;
    yv_nxt  = yv_r;
    ss_nxt  = ss_r;
    ph_nxt  = ph_r;
    we      = 1'b0;
    waddr   = pos_r[AW-1:0];
    wdata   = {key_r, ny_r};
    ra      = '0;
    rb      = '0;
    mstart  = 1'b0;
    dreq.start = 1'b0;
    dreq.num   = prod;
    dreq.den   = den_r;
    case (st_r)
      S_IDLE: begin
        yv_nxt  = '0;
        ss_nxt  = ST_OK;
        lo_nxt  = '0;
        hi_nxt  = cnt_r - CW'(1);
        pos_nxt = cnt_r;
        ph_nxt  = 2'd0;
        ra      = AW'(cnt_r - CW'(1));
        rb      = '0;
        if (start) begin
          case (op_t'(in_opcode))
            OP_CLEAR: cnt_nxt = '0;
            OP_ADD:   if (cnt_r >= CW'(TABLE_DEPTH)) ss_nxt = ST_FULL;
            OP_QUERY: if (cnt_r < CW'(2)) ss_nxt = ST_FEW;
            default:  ss_nxt = ST_OK;
          endcase
        end
      end
      S_RD_LAST: begin
        ra = AW'(cnt_r - CW'(1));
        rb = '0;
      end
      S_CHK_LAST: begin
        rb = '0;
        if (key_r > xa) ss_nxt = ST_ABOVE;
      end
      S_CHK_FIRST: begin
        if (key_r < xb) ss_nxt = ST_BELOW;
      end
      S_SRCH: begin
        ra = mid[AW-1:0];
        rb = lo_r[AW-1:0];
      end
      S_SRCH_W: begin
        if (xa < key_r) lo_nxt = mid + CW'(1);
        else            hi_nxt = mid;
      end
      S_RD_PAIR: begin
        ra = AW'(lo_r - CW'(1));
        rb = lo_r[AW-1:0];
        if (lo_r == '0) begin
          // key equals first x; y of first node was read with b = lo
          yv_nxt = yb;
        end
      end
      S_PAIR_W: begin
        mstart = 1'b1;
      end
      S_DIV: begin
        if (ph_r == 2'd0 && mdone) begin
          dreq.start = 1'b1;
          ph_nxt = 2'd2;
        end
        if (ph_r == 2'd2 && drsp.done) begin
          yv_nxt = neg_r ? (y0_r - $signed(drsp.quo)) : (y0_r + $signed(drsp.quo));
        end
      end
      S_INS_RD: begin
        ra = AW'(pos_r - CW'(1));
        if (pos_r == '0) begin
          we      = 1'b1;
          waddr   = '0;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_INS_W: begin
        ra = AW'(pos_r - CW'(1));
        we = 1'b1;
        if (xa > key_r) begin
          // move entry pos-1 up one place
          waddr   = pos_r[AW-1:0];
          wdata   = da;
          pos_nxt = pos_r - CW'(1);
        end else begin
          waddr   = pos_r[AW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: begin
        yv_nxt = yv_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ph_r  <= 2'd0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ph_r  <= ph_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    pos_r <= pos_nxt;
    yv_r  <= yv_nxt;
    ss_r  <= ss_nxt;
    if (st_r == S_IDLE && start) begin
      op_r  <= in_opcode;
      key_r <= in_key_x;
      ny_r  <= in_node_y;
    end
    if (st_r == S_PAIR_W) begin
      neg_r <= dy[32];
      y0_r  <= ya;
      den_r <= dden;
    end
  end

  // outputs
  always_comb begin
    busy        = (st_r != S_IDLE);
    out_valid   = (st_r == S_DONE);
    out_y_value = yv_r;
    out_status  = ss_r;
  end

`ifndef ASSERT_OFF
  // count never exceeds the depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH)) else $error("node count overflow");
  // a clear always leaves an empty table
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == OP_CLEAR) |-> cnt_r == '0) else $error("clear failed");
  // only queries carry a nonzero y
  a_y0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r != OP_QUERY) |-> out_y_value == 0) else $error("stray y");
  // write port only used while inserting
  a_we: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (op_r == OP_ADD && FB >= 0)) else $error("stray write");
`endif
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam int DEPTH = 256;
  localparam int N_WORDS = 1200;
  localparam longint CYCLE_LIMIT = 4000000;

  // Table shadow plus queue of expected result words
  class interp_scoreboard;
    logic signed [31:0] xs[DEPTH];
    logic signed [31:0] ys[DEPTH];
    int count;
    logic signed [31:0] want_y[$];
    status_t want_st[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return want_y.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // y0 + trunc(dy * (k - x0) / (x1 - x0))
    function logic signed [31:0] blend(logic signed [31:0] x0, logic signed [31:0] y0,
                                       logic signed [31:0] x1, logic signed [31:0] y1,
                                       logic signed [31:0] k);
      longint dy;
      longint unsigned num, den, mag, q;
      longint res;
      dy = longint'(y1) - longint'(y0);
      num = longint'(k) - longint'(x0);
      den = longint'(x1) - longint'(x0);
      mag = (dy < 0) ? -dy : dy;
      q = (mag * num) / den;
      res = (dy < 0) ? longint'(y0) - longint'(q) : longint'(y0) + longint'(q);
      return res[31:0];
    endfunction

    function status_t lookup(logic signed [31:0] k, output logic signed [31:0] y);
      int i;
      y = '0;
      if (count < 2) return ST_FEW;
      if (k > xs[count-1]) return ST_ABOVE;
      if (k < xs[0]) return ST_BELOW;
      i = 0;
      while (xs[i] < k) i++;
      if (i == 0) begin
        y = ys[0];
        return ST_OK;
      end
      y = blend(xs[i-1], ys[i-1], xs[i], ys[i], k);
      return ST_OK;
    endfunction

    // Accepted input word: update shadow table, queue expected result
    function void note_word(op_t op, logic signed [31:0] k, logic signed [31:0] ny);
      logic signed [31:0] y;
      status_t st;
      int pos;
      y = '0;
      st = ST_OK;
      case (op)
        OP_CLEAR: count = 0;
        OP_ADD: begin
          if (count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            pos = count;
            while (pos > 0 && xs[pos-1] > k) begin
              xs[pos] = xs[pos-1];
              ys[pos] = ys[pos-1];
              pos--;
            end
            xs[pos] = k;
            ys[pos] = ny;
            count++;
          end
        end
        OP_QUERY: st = lookup(k, y);
        default: ;
      endcase
      want_y.insert(want_y.size(), y);
      want_st.insert(want_st.size(), st);
    endfunction

    task check_word(logic signed [31:0] y, logic [2:0] st);
      logic signed [31:0] ey;
      status_t es;
      if (want_y.size() == 0) begin
        report($sformatf("unexpected result y=%0d status=%0d", y, st));
      end else begin
        ey = want_y.pop_front();
        es = want_st.pop_front();
        if (y !== ey) report($sformatf("y_value got %0d want %0d", y, ey));
        if (st !== es) report($sformatf("status got %0d want %0d", st, es));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_opcode;
  logic signed [31:0] in_key_x;
  logic signed [31:0] in_node_y;
  logic out_valid;
  logic signed [31:0] out_y_value;
  logic [2:0] out_status;

  interp_scoreboard sb;
  longint cycles;
  int words_sent;
  int fills;

  piecewise_linear_interp_table u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_key_x(in_key_x), .in_node_y(in_node_y),
    .out_valid(out_valid), .out_y_value(out_y_value), .out_status(out_status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_y_value, out_status);
  end

  // Hold start low for a random gap, mostly short
  task idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task send_word(op_t op, logic signed [31:0] k, logic signed [31:0] ny);
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_key_x = k;
    in_node_y = ny;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(op, k, ny);
    words_sent++;
    idle_gap();
  endtask

  task drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return ($signed($urandom_range(0, 40)) - 20) <<< 16;
      2: return ($signed($urandom_range(0, 2000)) - 1000) * 97 + $urandom_range(0, 3);
      default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                            : 32'sh80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  // Key mostly inside a node interval, sometimes at a node, just outside the range or anywhere
  function logic signed [31:0] pick_key(int mode);
    int i;
    longint x0, span;
    longint unsigned r;
    if (sb.count < 2 || $urandom_range(0, 5) == 0) return rand_coord(mode);
    i = $urandom_range(1, sb.count - 1);
    x0 = sb.xs[i-1];
    span = longint'(sb.xs[i]) - x0 + 1;
    case ($urandom_range(0, 5))
      0: return sb.xs[i];
      1: return sb.xs[0] - 1;
      2: return sb.xs[sb.count-1] + 1;
      default: begin
        r = {$urandom, $urandom};
        return x0 + longint'(r % span);
      end
    endcase
  endfunction

  initial begin
    int n, mode, q;
    sb = new();
    cycles = 0;
    words_sent = 0;
    fills = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_CLEAR;
    in_key_x = '0;
    in_node_y = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners
    send_word(OP_NOP, 32'sh7fffffff, 32'sh80000000);
    send_word(OP_QUERY, 0, 0);
    send_word(OP_ADD, 0, 32'sh80000000);
    send_word(OP_QUERY, 0, 0);
    send_word(OP_ADD, 32'sh7fffffff, 32'sh7fffffff);
    send_word(OP_QUERY, 32'sh80000000, 0);
    send_word(OP_QUERY, 0, 0);
    send_word(OP_QUERY, 32'sh7fffffff, 0);
    send_word(OP_QUERY, 32'sh7ffffffe, 0);
    send_word(OP_QUERY, 1, 0);
    send_word(OP_ADD, 32'sh80000000, 0);
    send_word(OP_QUERY, 32'sh80000000, 0);
    send_word(OP_QUERY, 32'sh80000001, 0);
    send_word(OP_ADD, 0, 5);
    send_word(OP_QUERY, 0, 0);
    send_word(OP_QUERY, -1, 0);
    send_word(OP_ADD, 32'sh7fffffff, 32'sh80000000);
    send_word(OP_QUERY, 32'sh7fffffff, 0);
    send_word(OP_QUERY, 32'sh40000000, 0);
    drain();
    send_word(OP_CLEAR, 32'sh7fffffff, 32'sh7fffffff);
    send_word(OP_QUERY, 0, 0);
    send_word(OP_NOP, 0, 0);

    // Random build-then-query segments
    while (words_sent < N_WORDS) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) drain();
      send_word($urandom_range(0, 9) == 0 ? OP_NOP : OP_CLEAR, $urandom, $urandom);
      if (fills < 3 && $urandom_range(0, 24) == 0) begin
        n = DEPTH + $urandom_range(1, 3);
        fills++;
      end else begin
        n = $urandom_range(0, 12);
      end
      for (int j = 0; j < n; j++) begin
        send_word(OP_ADD, (mode == 3 && j > 3) ? rand_coord(2) : rand_coord(mode), $urandom);
        if ($urandom_range(0, 15) == 0) send_word(OP_QUERY, pick_key(mode), $urandom);
      end
      q = $urandom_range(2, 14);
      repeat (q) begin
        case ($urandom_range(0, 19))
          0: send_word(OP_NOP, $urandom, $urandom);
          1: send_word(OP_ADD, rand_coord(mode), $urandom);
          default: send_word(OP_QUERY, pick_key(mode), $urandom);
        endcase
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.pending() != 0) sb.report("expected results left over");
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
